>>> sv/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, cell codes and the character lookup for the braille
// contraction encoder.
// ----------------------------------------------------------------------------
package bce_pkg;

    // Tokenizer hold codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_A    = 3'd1;
    localparam logic [2:0] ST_C    = 3'd2;
    localparam logic [2:0] ST_E    = 3'd3;
    localparam logic [2:0] ST_S    = 3'd4;
    localparam logic [2:0] ST_SC   = 3'd5;

    // Characters the tokenizer looks at
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_H = 8'h68;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Contraction cells
    localparam logic [5:0] CELL_AU  = 6'h21;
    localparam logic [5:0] CELL_EU  = 6'h23;
    localparam logic [5:0] CELL_EI  = 6'h29;
    localparam logic [5:0] CELL_CH  = 6'h39;
    localparam logic [5:0] CELL_SCH = 6'h31;
    localparam logic [5:0] CELL_ST  = 6'h3E;

    localparam int RES_SLOTS = 3;

    // One output cell with its flags
    typedef struct packed {
        logic [5:0] dots;
        logic       lb;
        logic       unk;
    } res_t;

    // All cells produced by one input byte
    typedef struct packed {
        res_t [RES_SLOTS-1:0] slots;
        logic [1:0]           count;
    } entry_t;

    // Front to queue
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    function automatic res_t plain_cell(input logic [5:0] dots);
        res_t r;
        r.dots = dots;
        r.lb   = 1'b0;
        r.unk  = 1'b0;
        return r;
    endfunction

    // Single character to cell
    function automatic res_t lookup_cell(input logic [7:0] ch);
        res_t r;
        r = plain_cell(6'h00);
        unique case (ch)
            CH_LF: r.lb = 1'b1;
            8'h61: r.dots = 6'h01; // a
            8'h62: r.dots = 6'h03;
            8'h63: r.dots = 6'h09;
            8'h64: r.dots = 6'h19;
            8'h65: r.dots = 6'h11;
            8'h66: r.dots = 6'h0B;
            8'h67: r.dots = 6'h1B;
            8'h68: r.dots = 6'h13;
            8'h69: r.dots = 6'h0A;
            8'h6A: r.dots = 6'h1A;
            8'h6B: r.dots = 6'h05;
            8'h6C: r.dots = 6'h07;
            8'h6D: r.dots = 6'h0D;
            8'h6E: r.dots = 6'h1D;
            8'h6F: r.dots = 6'h15;
            8'h70: r.dots = 6'h0F;
            8'h71: r.dots = 6'h1F;
            8'h72: r.dots = 6'h17;
            8'h73: r.dots = 6'h0E;
            8'h74: r.dots = 6'h1E;
            8'h75: r.dots = 6'h25;
            8'h76: r.dots = 6'h27;
            8'h77: r.dots = 6'h3A;
            8'h78: r.dots = 6'h2D;
            8'h79: r.dots = 6'h3D;
            8'h7A: r.dots = 6'h35; // z
            8'h20: r.dots = 6'h00; // space
            8'h2C: r.dots = 6'h02;
            8'h3B: r.dots = 6'h06;
            8'h3A: r.dots = 6'h12;
            8'h3F: r.dots = 6'h22;
            8'h21: r.dots = 6'h16;
            8'h28: r.dots = 6'h36;
            8'h29: r.dots = 6'h36;
            8'h2A: r.dots = 6'h14;
            8'h2E: r.dots = 6'h04;
            8'h2D: r.dots = 6'h24;
            8'h27: r.dots = 6'h20;
            default: r.unk = 1'b1;
        endcase
        return r;
    endfunction

endpackage

>>> sv/braille_contraction_encoder_core.sv
// ----------------------------------------------------------------------------
// braille_contraction_encoder_core
// ASCII text to six-dot braille cells with contraction of au, eu, ei, ch,
// sch and st.
// ----------------------------------------------------------------------------
// Usage:
//   Text channel: text_valid/text_stall carry text_byte and end_of_text.
//   A transfer happens on a clock edge with valid high and stall low.
//   Cell channel: cell_valid/cell_stall carry cell_dots, line_break,
//   unknown_char and last_of_run; dot n is bit n-1 of cell_dots.
//   Each byte yields zero to three cells; a byte that only extends a held
//   prefix yields none, and last_of_run marks the final cell of a byte.
//   The cells of a byte pass through the queue and then the output register.
//   Throughput: one cell per cycle out while cell_stall is low; a byte is
//   accepted every cycle while the two-entry queue between tokenizer and
//   output stage has room, so the sustained byte rate is set by the output
//   stage and by how many cells each byte produces.
//   When the receiver stalls, the output register holds its cell, the queue
//   fills and text_stall rises once both queue entries are taken.
//   Reset (rst_n low, asynchronous) empties the queue and output register
//   and drops any held letters.
// ----------------------------------------------------------------------------
module braille_contraction_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       cell_valid,
    input  logic       cell_stall,
    output logic [5:0] cell_dots,
    output logic       line_break,
    output logic       unknown_char,
    output logic       last_of_run
);
    import bce_pkg::*;

    push_t push;
    head_t head;
    logic  pop;
    logic  full;
    logic  accept;

    assign text_stall = full;
    assign accept     = text_valid && !full;

    bce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .push        (push)
    );

    bce_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    bce_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_dots    (cell_dots),
        .line_break   (line_break),
        .unknown_char (unknown_char),
        .last_of_run  (last_of_run)
    );

endmodule

>>> sv/bce_front.sv
// ----------------------------------------------------------------------------
// bce_front
// Tokenizer: holds prefix letters, forms contractions and builds the list
// of up to three cells for each accepted byte.
// ----------------------------------------------------------------------------
module bce_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     text_byte,
    input  logic           end_of_text,
    output bce_pkg::push_t push
);
    import bce_pkg::*;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       contr_hit;
    logic [5:0] contr_cell;
    logic       to_sc;
    res_t [1:0] rel;
    logic [1:0] rel_count;
    logic       holds;
    logic [2:0] hold_code;
    res_t       byte_res;
    entry_t     entry;

    // Contraction match against the held prefix
    always_comb
    begin
        contr_hit  = 1'b0;
        contr_cell = 6'h00;
        to_sc      = 1'b0;
        unique case (pending_reg)
            ST_A:
            begin
                if (text_byte == CH_U)
                begin
                    contr_hit  = 1'b1;
                    contr_cell = CELL_AU;
                end
            end
            ST_C:
            begin
                if (text_byte == CH_H)
                begin
                    contr_hit  = 1'b1;
                    contr_cell = CELL_CH;
                end
            end
            ST_E:
            begin
                if (text_byte == CH_I)
                begin
                    contr_hit  = 1'b1;
                    contr_cell = CELL_EI;
                end
                else if (text_byte == CH_U)
                begin
                    contr_hit  = 1'b1;
                    contr_cell = CELL_EU;
                end
            end
            ST_S:
            begin
                if (text_byte == CH_T)
                begin
                    contr_hit  = 1'b1;
                    contr_cell = CELL_ST;
                end
                else if (text_byte == CH_C)
                begin
                    to_sc = 1'b1;
                end
            end
            ST_SC:
            begin
                if (text_byte == CH_H)
                begin
                    contr_hit  = 1'b1;
                    contr_cell = CELL_SCH;
                end
            end
            default: ;
        endcase
    end

    // Held letters released as single cells
    always_comb
    begin
        rel[0]    = lookup_cell(CH_S);
        rel[1]    = lookup_cell(CH_C);
        rel_count = 2'd0;
        unique case (pending_reg)
            ST_A:
            begin
                rel[0]    = lookup_cell(CH_A);
                rel_count = 2'd1;
            end
            ST_C:
            begin
                rel[0]    = lookup_cell(CH_C);
                rel_count = 2'd1;
            end
            ST_E:
            begin
                rel[0]    = lookup_cell(CH_E);
                rel_count = 2'd1;
            end
            ST_S:    rel_count = 2'd1;
            ST_SC:   rel_count = 2'd2;
            default: rel_count = 2'd0;
        endcase
    end

    // Does the new byte start a prefix
    always_comb
    begin
        holds     = 1'b1;
        hold_code = ST_IDLE;
        unique case (text_byte)
            CH_A:    hold_code = ST_A;
            CH_C:    hold_code = ST_C;
            CH_E:    hold_code = ST_E;
            CH_S:    hold_code = ST_S;
            default: holds = 1'b0;
        endcase
    end

    assign byte_res = lookup_cell(text_byte);

    // Assemble the cell list and next hold state
    always_comb
    begin
        entry.slots[0] = rel[0];
        entry.slots[1] = rel[1];
        entry.slots[2] = byte_res;
        entry.count    = 2'd0;
        pending_next   = ST_IDLE;
        priority if (contr_hit)
        begin
            entry.slots[0] = plain_cell(contr_cell);
            entry.count    = 2'd1;
        end
        else if (to_sc)
        begin
            // sc pair; released at once on end of text
            entry.slots[0] = lookup_cell(CH_S);
            entry.slots[1] = lookup_cell(CH_C);
            if (end_of_text)
                entry.count = 2'd2;
            else
                pending_next = ST_SC;
        end
        else
        begin
            if (holds && !end_of_text)
            begin
                entry.count  = rel_count;
                pending_next = hold_code;
            end
            else
            begin
                // new byte goes directly after the released letters
                unique case (rel_count)
                    2'd0:    entry.slots[0] = byte_res;
                    2'd1:    entry.slots[1] = byte_res;
                    default: entry.slots[2] = byte_res;
                endcase
                entry.count = rel_count + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= ST_IDLE;
        else if (accept)
            pending_reg <= pending_next;
    end

    assign push.valid = accept && (entry.count != 2'd0);
    assign push.entry = entry;

endmodule

>>> sv/bce_queue.sv
// ----------------------------------------------------------------------------
// bce_queue
// Two-entry queue of per-byte cell lists between tokenizer and output stage.
// ----------------------------------------------------------------------------
module bce_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  bce_pkg::push_t  push,
    input  logic            pop,
    output bce_pkg::head_t  head,
    output logic            full
);
    import bce_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

    always_comb
    begin
        count_next = count_reg;
        unique case ({push.valid, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

endmodule

>>> sv/bce_back.sv
// ----------------------------------------------------------------------------
// bce_back
// Output stage: walks the cells of the queue head one per cycle, while the
// receiver does not stall, into the output register and marks the last cell of each byte.
// ----------------------------------------------------------------------------
module bce_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bce_pkg::head_t  head,
    output logic            pop,
    output logic            cell_valid,
    input  logic            cell_stall,
    output logic [5:0]      cell_dots,
    output logic            line_break,
    output logic            unknown_char,
    output logic            last_of_run
);
    import bce_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    res_t       res_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;
    res_t       sel;

    assign load = head.valid && (!valid_reg || !cell_stall);

    // Pick the current cell of the head entry
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel = head.entry.slots[0];
            2'd1:    sel = head.entry.slots[1];
            default: sel = head.entry.slots[2];
        endcase
    end

    assign is_last  = (idx_reg == head.entry.count - 2'd1);
    assign pop      = load && is_last;
    assign idx_next = is_last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!cell_stall)
                valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= sel;
            last_reg <= is_last;
        end
    end

    assign cell_valid   = valid_reg;
    assign cell_dots    = res_reg.dots;
    assign line_break   = res_reg.lb;
    assign unknown_char = res_reg.unk;
    assign last_of_run  = last_reg;

endmodule

>>> sv/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks for the braille contraction encoder, bound to the top.
// ----------------------------------------------------------------------------
module bce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cell_valid,
    input logic       cell_stall,
    input logic [5:0] cell_dots,
    input logic       line_break,
    input logic       unknown_char,
    input logic       last_of_run
);

    // Stalled cell stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |=> cell_valid)
        else $error("cell dropped while stalled");

    // Stalled cell keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |=> $stable(cell_dots) && $stable(last_of_run))
        else $error("cell payload changed while stalled");

    // Flag cells are blank and never both flags
    a_flag_blank: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && (line_break || unknown_char) |->
            cell_dots == 6'd0 && !(line_break && unknown_char))
        else $error("flagged cell not blank");

    // Newline and unknown bytes leave nothing held, so they end their run
    a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && (line_break || unknown_char) |-> last_of_run)
        else $error("flagged cell not last of run");

endmodule

bind braille_contraction_encoder_core bce_checker u_bce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_dots    (cell_dots),
    .line_break   (line_break),
    .unknown_char (unknown_char),
    .last_of_run  (last_of_run)
);
